### rtl/p22s_pkg.sv
// ----------------------------------------------------------------------------
// p22s_pkg
// Shared types and codes for the streaming 2x2 pooling block.
// ----------------------------------------------------------------------------
package p22s_pkg;

  // pooling modes, code 3 is handled as maximum
  localparam logic [1:0] MODE_MAX = 2'd0;
  localparam logic [1:0] MODE_MIN = 2'd1;
  localparam logic [1:0] MODE_AVG = 2'd2;

  // configuration register indexes
  localparam logic [1:0] REG_MODE     = 2'd0;
  localparam logic [1:0] REG_WIDTH    = 2'd1;
  localparam logic [1:0] REG_HEIGHT   = 2'd2;
  localparam logic [1:0] REG_CHANNELS = 2'd3;

  localparam int unsigned HEIGHT_LIMIT = 4096;
  localparam int unsigned WIDTH_FIELD  = 4095;
  localparam int unsigned QUEUE_DEPTH  = 4;

  // sizes are held already clamped to their legal range
  typedef struct packed {
    logic [1:0]  mode;
    logic [11:0] width;
    logic [12:0] height;
    logic [2:0]  chans;
  } cfg_t;

  // one horizontal pair handed from the front to the back
  typedef struct packed {
    logic       is_store;
    logic       last;
    logic [8:0] pair;
  } pair_op_t;

endpackage

### rtl/p22s_front.sv
// ----------------------------------------------------------------------------
// p22s_front
// Tracks the stream position, reduces each horizontal pair per channel and
// queues it as a store (even row) or an emit (odd row) operation.
// ----------------------------------------------------------------------------
module p22s_front import p22s_pkg::*; #(
  parameter int unsigned MAX_CHANNELS = 4,
  parameter int unsigned CHW          = 2,
  parameter int unsigned PW           = 10,
  parameter int unsigned CW           = 11
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  cfg_t                cfg_i,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  logic [7:0]          sample_i,
  input  logic                queue_full_i,
  output logic                push_o,
  output pair_op_t            push_op_o,
  output logic [PW+CHW-1:0]   push_addr_o
);

  logic [CHW-1:0] ch_q, ch_d;
  logic [CW-1:0]  col_q, col_d;
  logic [11:0]    row_q, row_d;
  logic [7:0]     left_q [MAX_CHANNELS];
  logic [7:0]     left;
  logic [8:0]     pair;
  logic           accept;
  logic           ch_last, col_last, row_last;

  assign accept     = in_valid_i && !queue_full_i;
  assign in_ready_o = !queue_full_i;
  assign left       = left_q[ch_q];

  always_comb begin
    case (cfg_i.mode)
      MODE_MIN: pair = (left < sample_i) ? {1'b0, left} : {1'b0, sample_i};
      MODE_AVG: pair = {1'b0, left} + {1'b0, sample_i};
      default:  pair = (left > sample_i) ? {1'b0, left} : {1'b0, sample_i};
    endcase
  end

  assign ch_last  = (16'(ch_q) + 16'd1) >= 16'(cfg_i.chans);
  assign col_last = (16'(col_q) + 16'd1) >= 16'(cfg_i.width);
  assign row_last = (16'(row_q) + 16'd1) >= 16'(cfg_i.height);

  assign push_o             = accept && col_q[0];
  assign push_op_o.is_store = !row_q[0];
  assign push_op_o.pair     = pair;
  // no later complete window in this row, column or channel
  assign push_op_o.last     = ((16'(row_q) + 16'd3) > 16'(cfg_i.height))
                           && ((16'(col_q) + 16'd3) > 16'(cfg_i.width))
                           && ch_last;
  assign push_addr_o        = {PW'(col_q >> 1), ch_q};

  always_comb begin
    ch_d  = ch_q;
    col_d = col_q;
    row_d = row_q;
    if (ch_last) begin
      ch_d = '0;
      if (col_last) begin
        col_d = '0;
        row_d = row_last ? 12'd0 : row_q + 12'd1;
      end else begin
        col_d = col_q + CW'(1);
      end
    end else begin
      ch_d = ch_q + CHW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ch_q  <= '0;
      col_q <= '0;
      row_q <= '0;
      for (int i = 0; i < int'(MAX_CHANNELS); i++) begin
        left_q[i] <= '0;
      end
    end else if (accept) begin
      ch_q  <= ch_d;
      col_q <= col_d;
      row_q <= row_d;
      if (!col_q[0]) begin
        left_q[ch_q] <= sample_i;
      end
    end
  end

endmodule

### rtl/p22s_fifo.sv
// ----------------------------------------------------------------------------
// p22s_fifo
// Short register queue between the front and the back.
// ----------------------------------------------------------------------------
module p22s_fifo import p22s_pkg::*; #(
  parameter int unsigned WIDTH = 23
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             pop_i,
  output logic [WIDTH-1:0] rdata_o,
  output logic             full_o,
  output logic             empty_o
);

  localparam int unsigned PTRW = $clog2(QUEUE_DEPTH);
  localparam int unsigned CNTW = $clog2(QUEUE_DEPTH + 1);

  logic [WIDTH-1:0] slot_q [QUEUE_DEPTH];
  logic [PTRW-1:0]  wr_q, rd_q;
  logic [CNTW-1:0]  cnt_q, cnt_d;

  assign rdata_o = slot_q[rd_q];
  assign full_o  = cnt_q == CNTW'(QUEUE_DEPTH);
  assign empty_o = cnt_q == '0;

  always_comb begin
    cnt_d = cnt_q;
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + CNTW'(1);
    end else if (pop_i && !push_i) begin
      cnt_d = cnt_q - CNTW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
      if (push_i) begin
        wr_q <= wr_q + PTRW'(1);
      end
      if (pop_i) begin
        rd_q <= rd_q + PTRW'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slot_q[wr_q] <= wdata_i;
    end
  end

endmodule

### rtl/p22s_back.sv
// ----------------------------------------------------------------------------
// p22s_back
// Holds the even-row pair reductions in a line memory and combines them with
// the odd-row pairs into pooled output beats.
// ----------------------------------------------------------------------------
module p22s_back import p22s_pkg::*; #(
  parameter int unsigned AW = 12
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic [1:0]     mode_i,
  input  logic           queue_empty_i,
  input  pair_op_t       head_op_i,
  input  logic [AW-1:0]  head_addr_i,
  output logic           pop_o,
  output logic           out_valid_o,
  input  logic           out_ready_i,
  output logic [7:0]     pooled_o,
  output logic           frame_end_o
);

  logic [8:0] line_mem [2**AW];
  logic [8:0] rd_q;
  logic [8:0] hold_q;
  logic       last_q;
  logic       v2_q, v2_d;
  logic       out_valid_q;
  logic [7:0] pooled_q, pooled_d;
  logic       frame_end_q;
  logic       out_free;
  logic       pop_emit;
  logic [9:0] sum;
  logic [8:0] st_lo;

  assign out_free = !out_valid_q || out_ready_i;
  assign pop_o    = !queue_empty_i && (head_op_i.is_store || !v2_q || out_free);
  assign pop_emit = pop_o && !head_op_i.is_store;

  // stored pair is used as it is, max and min see only its low byte
  assign sum   = {1'b0, rd_q} + {1'b0, hold_q};
  assign st_lo = {1'b0, rd_q[7:0]};

  always_comb begin
    case (mode_i)
      MODE_MIN: pooled_d = (st_lo < hold_q) ? st_lo[7:0] : hold_q[7:0];
      MODE_AVG: pooled_d = sum[9:2];
      default:  pooled_d = (st_lo > hold_q) ? st_lo[7:0] : hold_q[7:0];
    endcase
  end

  always_comb begin
    v2_d = v2_q;
    if (pop_emit) begin
      v2_d = 1'b1;
    end else if (out_free) begin
      v2_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o && head_op_i.is_store) begin
      line_mem[head_addr_i] <= head_op_i.pair;
    end
    if (pop_emit) begin
      rd_q   <= line_mem[head_addr_i];
      hold_q <= head_op_i.pair;
      last_q <= head_op_i.last;
    end
    if (out_free && v2_q) begin
      pooled_q    <= pooled_d;
      frame_end_q <= last_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v2_q        <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      v2_q <= v2_d;
      if (out_free) begin
        out_valid_q <= v2_q;
      end
    end
  end

  assign out_valid_o = out_valid_q;
  assign pooled_o    = pooled_q;
  assign frame_end_o = frame_end_q;

endmodule

### rtl/pool_2x2_stream.sv
// ----------------------------------------------------------------------------
// pool_2x2_stream
// Streaming 2x2 stride-2 pooling (max, min, truncated average) of 8-bit
// channel-interleaved raster samples.
// ----------------------------------------------------------------------------
// One sample is taken per clock with no gaps of its own; the block stalls
// input only when its 4-entry pair queue is full, which happens only while
// the output side holds back. After its last sample is accepted, a result
// passes the queue, line memory read and output register. Even rows
// are reduced pairwise and parked in a line memory of (MAX_WIDTH/2) x 2^k
// words of 9 bits; odd rows read it back. The line memory is not cleared.
// Configuration is taken any cycle but must only change while no pixel work
// is in flight; size fields of 0 act as 1, oversized fields saturate.
module pool_2x2_stream import p22s_pkg::*; #(
  parameter int unsigned MAX_WIDTH    = 2048,
  parameter int unsigned MAX_CHANNELS = 4
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [1:0]  cfg_index_i,
  input  logic [12:0] cfg_data_i,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [7:0]  sample_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [7:0]  pooled_o,
  output logic        frame_end_o
);

  localparam int unsigned CHW   = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
  localparam int unsigned NPAIR = MAX_WIDTH / 2;
  localparam int unsigned PW    = (NPAIR > 1) ? $clog2(NPAIR) : 1;
  localparam int unsigned CW    = $clog2(MAX_WIDTH);
  localparam int unsigned AW    = PW + CHW;
  localparam int unsigned QW    = $bits(pair_op_t) + AW;
  localparam int unsigned W_LIM = (MAX_WIDTH > WIDTH_FIELD) ? WIDTH_FIELD : MAX_WIDTH;
  localparam int unsigned W_RST = (MAX_WIDTH > 2048) ? 2048 : MAX_WIDTH;
  localparam int unsigned C_RST = (MAX_CHANNELS > 3) ? 3 : MAX_CHANNELS;

  logic [1:0]  mode_q;
  logic [11:0] width_q;
  logic [12:0] height_q;
  logic [2:0]  chans_q;
  cfg_t        cfg;

  logic           push;
  pair_op_t       push_op;
  logic [AW-1:0]  push_addr;
  logic           pop;
  logic           q_full, q_empty;
  logic [QW-1:0]  q_rdata;
  pair_op_t       head_op;
  logic [AW-1:0]  head_addr;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q   <= MODE_MAX;
      width_q  <= 12'(W_RST);
      height_q <= 13'd2048;
      chans_q  <= 3'(C_RST);
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        REG_MODE: begin
          mode_q <= cfg_data_i[1:0];
        end
        REG_WIDTH: begin
          if (cfg_data_i[11:0] == '0) begin
            width_q <= 12'd1;
          end else if (16'(cfg_data_i[11:0]) > 16'(W_LIM)) begin
            width_q <= 12'(W_LIM);
          end else begin
            width_q <= cfg_data_i[11:0];
          end
        end
        REG_HEIGHT: begin
          if (cfg_data_i == '0) begin
            height_q <= 13'd1;
          end else if (16'(cfg_data_i) > 16'(HEIGHT_LIMIT)) begin
            height_q <= 13'(HEIGHT_LIMIT);
          end else begin
            height_q <= cfg_data_i;
          end
        end
        REG_CHANNELS: begin
          if (cfg_data_i[2:0] == '0) begin
            chans_q <= 3'd1;
          end else if (8'(cfg_data_i[2:0]) > 8'(MAX_CHANNELS)) begin
            chans_q <= 3'(MAX_CHANNELS);
          end else begin
            chans_q <= cfg_data_i[2:0];
          end
        end
        default: begin
        end
      endcase
    end
  end

  assign cfg.mode   = mode_q;
  assign cfg.width  = width_q;
  assign cfg.height = height_q;
  assign cfg.chans  = chans_q;

  p22s_front #(
    .MAX_CHANNELS (MAX_CHANNELS),
    .CHW          (CHW),
    .PW           (PW),
    .CW           (CW)
  ) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .sample_i     (sample_i),
    .queue_full_i (q_full),
    .push_o       (push),
    .push_op_o    (push_op),
    .push_addr_o  (push_addr)
  );

  p22s_fifo #(
    .WIDTH (QW)
  ) u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .wdata_i ({push_op, push_addr}),
    .pop_i   (pop),
    .rdata_o (q_rdata),
    .full_o  (q_full),
    .empty_o (q_empty)
  );

  assign head_op   = q_rdata[QW-1:AW];
  assign head_addr = q_rdata[AW-1:0];

  p22s_back #(
    .AW (AW)
  ) u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .mode_i        (mode_q),
    .queue_empty_i (q_empty),
    .head_op_i     (head_op),
    .head_addr_i   (head_addr),
    .pop_o         (pop),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .pooled_o      (pooled_o),
    .frame_end_o   (frame_end_o)
  );

`ifndef SYNTHESIS
  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push |-> !q_full)
    else $error("pair queue written while full");

  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop |-> !q_empty)
    else $error("pair queue read while empty");

  a_push_on_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push |-> (in_valid_i && in_ready_o))
    else $error("pair pushed without an accepted beat");
`endif

endmodule
